// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the blob centroid RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define CBC_ASSERT_IMP(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CBC_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cbc_pkg.sv =====
// Shared types, widths and constants of the blob centroid core.
// No dependencies; every other file but assert_macros.svh imports it.
package cbc_pkg;

  localparam int COLOR_W    = 8;
  localparam int COORD_W    = 10;
  localparam int MEAN_W     = 14;
  localparam int CNT_OUT_W  = 21;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int QUOT20_W   = 7;
  localparam int THR_W      = 2 * QUOT20_W;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_FRAC_BITS  = 4;
  localparam int DEF_FIFO_DEPTH = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd240;

  // Blueness test: 5*b > 6*c + 50 against both other channels.
  localparam int BLUE_LHS_MUL = 5;
  localparam int BLUE_RHS_MUL = 6;
  localparam int BLUE_OFFSET  = 50;
  localparam int TEST_W       = 11;

  // v / 20 for v < 2048 as (v * 3277) >> 16.
  localparam int RECIP20       = 3277;
  localparam int RECIP20_SHIFT = 16;
  localparam int RECIP20_W     = 12;
  localparam int PROD20_W      = CFG_W + RECIP20_W;

  // Classified pixel as held in the queue.
  typedef struct packed {
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic               blue;
    logic               frame_end;
  } item_t;

  function automatic logic [QUOT20_W-1:0] div20(input logic [CFG_W-1:0] v);
    logic [PROD20_W-1:0] prod;
    prod = PROD20_W'(v) * PROD20_W'(RECIP20);
    return prod[RECIP20_SHIFT +: QUOT20_W];
  endfunction

endpackage

// ===== hdl/cbc_if.sv =====
// Stream interfaces of the blob centroid core: pixel requests in, results out.
// Depends on cbc_pkg for the field widths.
interface cbc_pix_if import cbc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COORD_W-1:0] x_pos;
  logic [COORD_W-1:0] y_pos;
  logic               frame_end;

  modport source (output valid, red, green, blue, x_pos, y_pos, frame_end, input ready);
  modport sink   (input valid, red, green, blue, x_pos, y_pos, frame_end, output ready);
endinterface

interface cbc_res_if import cbc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [MEAN_W-1:0]    mean_x;
  logic [MEAN_W-1:0]    mean_y;
  logic [CNT_OUT_W-1:0] blue_count;

  modport source (output valid, mean_x, mean_y, blue_count, input ready);
  modport sink   (input valid, mean_x, mean_y, blue_count, output ready);
endinterface

// ===== hdl/cbc_front.sv =====
// Front end: classify each pixel request as blue or not and push it to the queue.
// Depends on cbc_pkg and cbc_pix_if.
module cbc_front import cbc_pkg::*; (
  cbc_pix_if.sink pix_i,
  input  logic    full_i,
  output logic    push_o,
  output item_t   item_o
);

  logic [TEST_W-1:0] lhs;
  logic [TEST_W-1:0] rhs_r;
  logic [TEST_W-1:0] rhs_g;

  always_comb begin
    lhs   = TEST_W'(BLUE_LHS_MUL) * TEST_W'(pix_i.blue);
    rhs_r = TEST_W'(BLUE_RHS_MUL) * TEST_W'(pix_i.red) + TEST_W'(BLUE_OFFSET);
    rhs_g = TEST_W'(BLUE_RHS_MUL) * TEST_W'(pix_i.green) + TEST_W'(BLUE_OFFSET);
  end

  assign item_o.x_pos     = pix_i.x_pos;
  assign item_o.y_pos     = pix_i.y_pos;
  assign item_o.blue      = (lhs > rhs_r) && (lhs > rhs_g);
  assign item_o.frame_end = pix_i.frame_end;

  assign pix_i.ready = !full_i;
  assign push_o      = pix_i.valid && !full_i;

endmodule

// ===== hdl/cbc_fifo.sv =====
// Short queue of classified pixels between the front end and the accumulator.
// Depends on cbc_pkg for item_t.
module cbc_fifo import cbc_pkg::*; #(
  parameter int DEPTH = DEF_FIFO_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/cbc_back.sv =====
// Back end: frame-size registers, detection threshold and running sums.
// Depends on cbc_pkg; hands finished frames to cbc_div.
module cbc_back import cbc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  parameter int SUM_W      = CNT_W + COORD_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 valid_i,
  input  item_t                item_i,
  output logic                 pop_o,
  input  logic                 busy_i,
  output logic                 start_o,
  output logic [SUM_W-1:0]     sum_x_o,
  output logic [SUM_W-1:0]     sum_y_o,
  output logic [CNT_W-1:0]     count_o
);

  localparam int unsigned CAP   = MAX_WIDTH * MAX_HEIGHT;
  localparam int          CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  logic [CFG_W-1:0]    width_q, height_q;
  logic [QUOT20_W-1:0] wq_q, hq_q;
  logic [THR_W-1:0]    thr;
  logic [SUM_W-1:0]    sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      wq_q     <= div20(FRAME_WIDTH_RST);
      hq_q     <= div20(FRAME_HEIGHT_RST);
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
      wq_q <= div20(width_q);
      hq_q <= div20(height_q);
    end
  end

  assign thr = THR_W'(wq_q) * THR_W'(hq_q);

  always_comb begin
    hit     = item_i.blue && (cnt_q < CNT_W'(CAP));
    sum_x_o = sum_x_q + (hit ? SUM_W'(item_i.x_pos) : '0);
    sum_y_o = sum_y_q + (hit ? SUM_W'(item_i.y_pos) : '0);
    count_o = cnt_q + CNT_W'(hit);
    // Hold a frame end while the divider still owns the previous frame.
    pop_o   = valid_i && !(item_i.frame_end && busy_i);
    start_o = pop_o && item_i.frame_end && (CMP_W'(count_o) > CMP_W'(thr));
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    if (pop_o) begin
      if (item_i.frame_end) begin
        sum_x_d = '0;
        sum_y_d = '0;
        cnt_d   = '0;
      end else begin
        sum_x_d = sum_x_o;
        sum_y_d = sum_y_o;
        cnt_d   = count_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
    end else begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/cbc_div.sv =====
// Two-lane restoring divider for the centroid means, with its result register.
// Depends on cbc_pkg, cbc_res_if and assert_macros.svh.
`include "assert_macros.svh"

module cbc_div import cbc_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int CNT_W     = $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT + 1),
  parameter int SUM_W     = CNT_W + COORD_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] sum_x_i,
  input  logic [SUM_W-1:0] sum_y_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             busy_o,
  cbc_res_if.source        res_o
);

  // Quotient stays below 2^(COORD_W + FRAC_BITS) since each mean is under 2^COORD_W.
  localparam int QW     = COORD_W + FRAC_BITS;
  localparam int STEP_W = $clog2(QW + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  den_q;
  logic [CNT_W-1:0]  rem_q [2];
  logic [CNT_W-1:0]  rem_d [2];
  logic [QW-1:0]     quo_q [2];
  logic [QW-1:0]     quo_d [2];
  logic [CNT_W:0]    trial [2];
  logic [SUM_W-1:0]  sum_in [2];

  assign sum_in[0] = sum_x_i;
  assign sum_in[1] = sum_y_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_q[l], quo_q[l][QW-1]};
      rem_d[l] = rem_q[l];
      quo_d[l] = quo_q[l];
      if (start_i) begin
        rem_d[l] = sum_in[l][SUM_W-1:COORD_W];
        quo_d[l] = QW'(sum_in[l][COORD_W-1:0]) << FRAC_BITS;
      end else if (state_q == ST_RUN) begin
        if (trial[l] >= {1'b0, den_q}) begin
          rem_d[l] = CNT_W'(trial[l] - {1'b0, den_q});
          quo_d[l] = {quo_q[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[l][CNT_W-1:0];
          quo_d[l] = {quo_q[l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          step_d  = STEP_W'(QW - 1);
        end
      end
      ST_RUN: begin
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= count_i;
    end
    for (int l = 0; l < 2; l++) begin
      rem_q[l] <= rem_d[l];
      quo_q[l] <= quo_d[l];
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign res_o.valid      = (state_q == ST_DONE);
  assign res_o.mean_x     = MEAN_W'(quo_q[0]);
  assign res_o.mean_y     = MEAN_W'(quo_q[1]);
  assign res_o.blue_count = CNT_OUT_W'(den_q);

  `CBC_ASSERT_IMP(a_start_idle, start_i, state_q == ST_IDLE, "divider started while busy")
  `CBC_ASSERT_IMP(a_start_nonzero, start_i, count_i != '0, "divider started with zero count")
  `CBC_ASSERT_IMP(a_rem_bound, state_q == ST_RUN, (rem_q[0] < den_q) && (rem_q[1] < den_q),
    "partial remainder not below divisor")
  `CBC_ASSERT_NEXT(a_run_ends, (state_q == ST_RUN) && (step_q == '0), state_q == ST_DONE,
    "divider did not finish on last step")

endmodule

// ===== hdl/color_blob_centroid_core.sv =====
// Blue-blob centroid core: accepts one pixel per cycle while its queue has room;
// a frame end is held only while the previous frame's means are still being divided or
// wait to be taken. Once the frame-end pixel leaves the queue, a blob above the
// threshold starts the one-bit-per-cycle divider, whose result is valid when done.
// Reset: sums and hit count clear, frame size returns to 320 x 240, no result pending.
module color_blob_centroid_core import cbc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cbc_pix_if.sink              pix_i,
  cbc_res_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // Hit count saturates at MAX_WIDTH*MAX_HEIGHT; sums widen by the coordinate width.
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUM_W = CNT_W + COORD_W;

  item_t            front_item, queue_item;
  logic             push, full, queue_valid, pop;
  logic             div_start, div_busy;
  logic [SUM_W-1:0] fin_sum_x, fin_sum_y;
  logic [CNT_W-1:0] fin_count;

  // Classify the pixel request as blue or not.
  cbc_front u_front (
    .pix_i  (pix_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  // Decouple pixel intake from the accumulator, so a held frame end stalls the
  // stream only once the queue fills.
  cbc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  // Accumulate blue pixels; on a frame end compare against the threshold, launch the
  // divider if the blob is large enough and clear the sums either way.
  cbc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .valid_i    (queue_valid),
    .item_i     (queue_item),
    .pop_o      (pop),
    .busy_i     (div_busy),
    .start_o    (div_start),
    .sum_x_o    (fin_sum_x),
    .sum_y_o    (fin_sum_y),
    .count_o    (fin_count)
  );

  // Divide both sums by the count and hold the result until it is taken.
  cbc_div #(
    .FRAC_BITS (FRAC_BITS),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_x_i (fin_sum_x),
    .sum_y_i (fin_sum_y),
    .count_i (fin_count),
    .busy_o  (div_busy),
    .res_o   (res_o)
  );

endmodule
